// ===== rtl/graph_reachability_without_vertex_assert.svh =====
// Assertion macros for the graph reachability block.
`ifndef GRAPH_REACHABILITY_WITHOUT_VERTEX_ASSERT_SVH
`define GRAPH_REACHABILITY_WITHOUT_VERTEX_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define GRWV_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("grwv: property violated");

// Check a property on every clock edge, reset included.
`define GRWV_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("grwv: property violated during reset");

`endif

// ===== rtl/grwv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package grwv_pkg;

  // Key width of the command fields.
  localparam int CMD_KEY_W = 16;

  // Command kinds.
  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_EDGE  = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef struct packed {
    kind_e                kind;
    logic [CMD_KEY_W-1:0] key_a;
    logic [CMD_KEY_W-1:0] key_b;
  } cmd_t;

  typedef struct packed {
    status_e status;
    logic    connected;
  } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/graph_reachability_without_vertex.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sequence: add vertex and the unused kind report straight from idle; add edge runs the
//   one-entry-per-cycle key scan, then reads and writes back the source row; query runs
//   the key scan, then an adjacency read loop that reads one row per reached vertex.
// A new command is taken only while idle; busy stays high while an edge or query is in flight.
// The receiver cannot stall: each result shows on done_o for one cycle.
// Reset (async, active low) empties the graph; no clearing pass is needed.
module graph_reachability_without_vertex #(
  parameter int MAX_NODES = 16,
  parameter int KEY_WIDTH = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start,
  output logic                 busy,
  input  wire grwv_pkg::cmd_t  cmd_i,
  output logic                 done_o,
  output grwv_pkg::rsp_t       result_o
);
  import grwv_pkg::*;

  localparam int KeyW = (KEY_WIDTH < CMD_KEY_W) ? KEY_WIDTH : CMD_KEY_W;
  localparam int IdxW = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
  localparam int CntW = $clog2(MAX_NODES + 1);
  localparam logic [MAX_NODES-1:0] OneHot = {{(MAX_NODES-1){1'b0}}, 1'b1};

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_EREAD  = 3'd2;
  localparam logic [2:0] S_EWRITE = 3'd3;
  localparam logic [2:0] S_XISSUE = 3'd4;
  localparam logic [2:0] S_XWAIT  = 3'd5;

  logic [2:0]           state_q, state_d;
  cmd_t                 cmd_q, cmd_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [CntW-1:0]      scan_q, scan_d;
  logic                 rv_q, rv_d;
  logic [IdxW-1:0]      ridx_q, ridx_d;
  logic [IdxW-1:0]      src_q, src_d, dst_q, dst_d, first_q, first_d;
  logic                 src_ok_q, src_ok_d, dst_ok_q, dst_ok_d, first_ok_q, first_ok_d;
  logic [MAX_NODES-1:0] active_q, active_d;
  logic [MAX_NODES-1:0] reached_q, reached_d;
  logic [MAX_NODES-1:0] pending_q, pending_d;
  logic                 done_q, done_d;
  rsp_t                 rsp_q, rsp_d;

  // Memory ports
  logic [KeyW-1:0]      key_mem [MAX_NODES];
  logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
  logic                 key_we, adj_we;
  logic [IdxW-1:0]      key_waddr, adj_waddr, key_raddr, adj_raddr;
  logic [KeyW-1:0]      key_wdata, key_rdata_q;
  logic [MAX_NODES-1:0] adj_wdata, adj_rdata_q;

  // Expansion helpers
  logic [MAX_NODES-1:0] low_bit, grow;
  logic [IdxW-1:0]      low_idx;

  // Key table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    key_rdata_q <= key_mem[key_raddr];
  end

  // Adjacency rows: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    adj_rdata_q <= adj_mem[adj_raddr];
  end

  // Pick the lowest pending vertex to expand
  always_comb begin
    low_bit = pending_q & (~pending_q + OneHot);
    low_idx = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      if (low_bit[i]) begin
        low_idx = low_idx | IdxW'(i);
      end
    end
  end

  assign grow = adj_rdata_q & active_q & ~reached_q;

  // Sequence the commands
  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    count_d    = count_q;
    scan_d     = scan_q;
    rv_d       = 1'b0;
    ridx_d     = ridx_q;
    src_d      = src_q;
    dst_d      = dst_q;
    first_d    = first_q;
    src_ok_d   = src_ok_q;
    dst_ok_d   = dst_ok_q;
    first_ok_d = first_ok_q;
    active_d   = active_q;
    reached_d  = reached_q;
    pending_d  = pending_q;
    done_d     = 1'b0;
    rsp_d      = rsp_q;
    key_we     = 1'b0;
    adj_we     = 1'b0;
    key_waddr  = count_q[IdxW-1:0];
    key_wdata  = cmd_i.key_a[KeyW-1:0];
    adj_waddr  = count_q[IdxW-1:0];
    adj_wdata  = '0;
    key_raddr  = scan_q[IdxW-1:0];
    adj_raddr  = src_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d           = cmd_i;
          rsp_d.status    = ST_DONE;
          rsp_d.connected = 1'b0;
          case (cmd_i.kind) inside
            KIND_ADD: begin
              done_d = 1'b1;
              if (count_q == CntW'(MAX_NODES)) begin
                rsp_d.status = ST_FULL;
              end else begin
                key_we  = 1'b1;
                adj_we  = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            KIND_EDGE, KIND_QUERY: begin
              scan_d     = '0;
              src_ok_d   = 1'b0;
              dst_ok_d   = 1'b0;
              first_ok_d = 1'b0;
              active_d   = '0;
              state_d    = S_SCAN;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue one key read per cycle
        if (scan_q < count_q) begin
          rv_d   = 1'b1;
          ridx_d = scan_q[IdxW-1:0];
          scan_d = scan_q + 1'b1;
        end
        // Match the returned key
        if (rv_q) begin
          if (!src_ok_q && key_rdata_q == cmd_q.key_a[KeyW-1:0]) begin
            src_ok_d = 1'b1;
            src_d    = ridx_q;
          end
          if (!dst_ok_q && key_rdata_q == cmd_q.key_b[KeyW-1:0]) begin
            dst_ok_d = 1'b1;
            dst_d    = ridx_q;
          end
          if (key_rdata_q != cmd_q.key_a[KeyW-1:0]) begin
            active_d = active_q | (OneHot << ridx_q);
            if (!first_ok_q) begin
              first_ok_d = 1'b1;
              first_d    = ridx_q;
            end
          end
        end
        // Branch once the scan has drained
        if (scan_q == count_q && !rv_q) begin
          if (cmd_q.kind == KIND_EDGE) begin
            if (src_ok_q && dst_ok_q) begin
              state_d = S_EREAD;
            end else begin
              done_d       = 1'b1;
              rsp_d.status = ST_NOT_FOUND;
              state_d      = S_IDLE;
            end
          end else if (first_ok_q) begin
            reached_d = OneHot << first_q;
            pending_d = OneHot << first_q;
            state_d   = S_XISSUE;
          end else begin
            done_d          = 1'b1;
            rsp_d.connected = 1'b1;
            state_d         = S_IDLE;
          end
        end
      end

      S_EREAD: begin
        adj_raddr = src_q;
        state_d   = S_EWRITE;
      end

      S_EWRITE: begin
        // Write back the source row with the new edge
        adj_we    = 1'b1;
        adj_waddr = src_q;
        adj_wdata = adj_rdata_q | (OneHot << dst_q);
        done_d    = 1'b1;
        state_d   = S_IDLE;
      end

      S_XISSUE: begin
        if (pending_q == '0) begin
          done_d          = 1'b1;
          rsp_d.connected = ((active_q & ~reached_q) == '0);
          state_d         = S_IDLE;
        end else begin
          adj_raddr = low_idx;
          pending_d = pending_q & ~low_bit;
          state_d   = S_XWAIT;
        end
      end

      S_XWAIT: begin
        // Absorb the successors of the expanded vertex
        reached_d = reached_q | grow;
        pending_d = pending_q | grow;
        state_d   = S_XISSUE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      rv_q       <= 1'b0;
      done_q     <= 1'b0;
      src_ok_q   <= 1'b0;
      dst_ok_q   <= 1'b0;
      first_ok_q <= 1'b0;
      scan_q     <= '0;
      active_q   <= '0;
      reached_q  <= '0;
      pending_q  <= '0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      rv_q       <= rv_d;
      done_q     <= done_d;
      src_ok_q   <= src_ok_d;
      dst_ok_q   <= dst_ok_d;
      first_ok_q <= first_ok_d;
      scan_q     <= scan_d;
      active_q   <= active_d;
      reached_q  <= reached_d;
      pending_q  <= pending_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    ridx_q  <= ridx_d;
    src_q   <= src_d;
    dst_q   <= dst_d;
    first_q <= first_d;
    rsp_q   <= rsp_d;
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = rsp_q;

endmodule

`default_nettype wire

// ===== rtl/grwv_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "graph_reachability_without_vertex_assert.svh"

module grwv_checker (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 start,
  input wire                 busy,
  input wire grwv_pkg::cmd_t cmd_i,
  input wire                 done_o,
  input wire grwv_pkg::rsp_t result_o
);
  import grwv_pkg::*;

  // Stay quiet while in reset
  `GRWV_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> (!done_o && !busy))

  // Add and unused-kind commands report in the next cycle
  `GRWV_ASSERT(a_quick_done,
    (start && !busy && (cmd_i.kind == KIND_ADD || cmd_i.kind == KIND_RSVD)) |=> done_o)

  // Graph commands go busy without an early result
  `GRWV_ASSERT(a_walk_busy,
    (start && !busy && (cmd_i.kind == KIND_EDGE || cmd_i.kind == KIND_QUERY))
      |=> (busy && !done_o))

  // Busy drops only together with a result
  `GRWV_ASSERT(a_busy_ends_done, $fell(busy) |-> done_o)

  // A failing status never reports connectivity
  `GRWV_ASSERT(a_status_conn,
    done_o |-> (result_o.status == ST_DONE || !result_o.connected))

endmodule

bind graph_reachability_without_vertex grwv_checker u_grwv_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .cmd_i    (cmd_i),
  .done_o   (done_o),
  .result_o (result_o)
);

`default_nettype wire
